### rtl/lmcs_pkg.sv
// Shared types and constants for the LED matrix column scan shifter.
`timescale 1ns / 1ps
package lmcs_pkg;

  localparam int unsigned LEVEL_BITS  = 12;
  localparam int unsigned CHAIN_ROWS  = 8;
  localparam int unsigned PIXEL_BITS  = 3 * LEVEL_BITS;
  localparam int unsigned BUF_BITS    = PIXEL_BITS + 4;
  localparam logic [15:0] DWELL_RESET = 16'd250;

  // Byte phases within one pair of rows: nine bytes carry two 36-bit rows.
  localparam logic [3:0] PH_FIRST = 4'd0;
  localparam logic [3:0] PH_SPLIT = 4'd4;
  localparam logic [3:0] PH_LAST  = 4'd8;
  localparam logic [1:0] PAIR_LAST = 2'd3;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_CLEAR = 2'd1,
    OP_TICK  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [1:0]            operation;
    logic [3:0]            x;
    logic [2:0]            y;
    logic [LEVEL_BITS-1:0] red;
    logic [LEVEL_BITS-1:0] green;
    logic [LEVEL_BITS-1:0] blue;
  } cmd_t;

  typedef struct packed {
    logic [3:0] column;
    logic [7:0] data_byte;
    logic       last;
  } result_t;

  // Shift order of one row: blue, red, green, each MSB first.
  typedef struct packed {
    logic [LEVEL_BITS-1:0] blue;
    logic [LEVEL_BITS-1:0] red;
    logic [LEVEL_BITS-1:0] green;
  } pixel_t;

endpackage

### rtl/lmcs_pixel_store.sv
// Framebuffer memory with per-pixel valid bits and a registered read port.
`timescale 1ns / 1ps
module lmcs_pixel_store #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = 7
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_en_i,
  input  logic [AW-1:0]   wr_addr_i,
  input  lmcs_pkg::pixel_t wr_data_i,
  input  logic            clr_i,
  input  logic            rd_en_i,
  input  logic [AW-1:0]   rd_addr_i,
  output lmcs_pkg::pixel_t rd_data_o
);
  import lmcs_pkg::*;

  pixel_t           mem_q [DEPTH];
  pixel_t           rd_data_q;
  logic [DEPTH-1:0] valid_q;
  logic             rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // Clear drops every valid bit at once; an invalid entry reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (clr_i) begin
        valid_q <= '0;
      end else if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

### rtl/led_matrix_column_scan_shifter.sv
// Top level of the LED matrix column scan shifter: command decode, dwell and byte serialiser.
//
//   channel   direction  handshake                      payload
//   command   in         start high, busy low at edge   cmd_i     (lmcs_pkg::cmd_t)
//   result    out        result_valid_o, one cycle      result_o  (lmcs_pkg::result_t)
//   config    in         cfg_we_i high at edge          cfg_wdata_i (column_dwell)
//
// Pixel write, clear and a tick that only counts down complete in the accept
// cycle; busy stays low. A tick that finds the dwell counter at zero first
// reads the top framebuffer row in the prep state, then emits 36 bytes, one per cycle,
// from the byte-wide shift register that drains one 36-bit row per 4.5 bytes.
// Results leave through an output register, in the cycle after the byte is formed.
// Reset clears the valid bits of the framebuffer at once: no clearing pass.
// The receiver cannot stall; every result is a transaction on its own cycle.
`timescale 1ns / 1ps
module led_matrix_column_scan_shifter #(
  parameter int unsigned NUM_COLUMNS = 16,
  parameter int unsigned NUM_ROWS    = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  lmcs_pkg::cmd_t    cmd_i,
  output logic              result_valid_o,
  output lmcs_pkg::result_t result_o,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i
);
  import lmcs_pkg::*;

  localparam int unsigned CW        = $clog2(NUM_COLUMNS);
  localparam int unsigned AW        = CW + 3;
  localparam int unsigned MEM_DEPTH = NUM_COLUMNS * CHAIN_ROWS;

  state_e               state_q, state_d;
  logic [15:0]          dwell_cfg_q;
  logic [15:0]          dwell_q, dwell_d;
  logic [CW-1:0]        scan_col_q, scan_col_d;
  logic [3:0]           phase_q, phase_d;
  logic [1:0]           pair_q, pair_d;
  logic [BUF_BITS-1:0]  buf_q, buf_d;
  logic [BUF_BITS-1:0]  cur;
  result_t              result_q, result_d;
  logic                 result_valid_q, result_valid_d;

  logic                 accept;
  logic                 do_write, do_clear, do_tick, scan_go;
  logic [AW-1:0]        wr_addr;
  pixel_t               wr_data;
  logic                 rd_en;
  logic [2:0]           rd_row;
  pixel_t               rd_data;
  logic                 last_byte;

  assign accept   = start && !busy;
  assign do_write = accept && (cmd_i.operation == OP_WRITE)
                    && (32'(cmd_i.x) < NUM_COLUMNS) && (32'(cmd_i.y) < NUM_ROWS);
  assign do_clear = accept && (cmd_i.operation == OP_CLEAR);
  assign do_tick  = accept && (cmd_i.operation == OP_TICK);
  assign scan_go  = do_tick && (dwell_q == 16'd0);

  assign wr_addr = {cmd_i.x[CW-1:0], cmd_i.y};
  assign wr_data = '{blue: cmd_i.blue, red: cmd_i.red, green: cmd_i.green};

  assign last_byte = (state_q == ST_EMIT) && (pair_q == PAIR_LAST) && (phase_q == PH_LAST);

  lmcs_pixel_store #(
    .DEPTH (MEM_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (do_write),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .clr_i     (do_clear),
    .rd_en_i   (rd_en),
    .rd_addr_i ({scan_col_q, rd_row}),
    .rd_data_o (rd_data)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (scan_go) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (last_byte) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Datapath control and outputs.
  always_comb begin
    dwell_d        = dwell_q;
    scan_col_d     = scan_col_q;
    phase_d        = phase_q;
    pair_d         = pair_q;
    buf_d          = buf_q;
    cur            = buf_q;
    rd_en          = 1'b0;
    rd_row         = 3'(CHAIN_ROWS - 1);
    result_valid_d = 1'b0;
    result_d       = result_q;

    unique case (state_q)
      ST_IDLE: begin
        // Count down, or reload the dwell counter to open a scan; the prep state fetches the top row.
        if (do_tick) begin
          if (dwell_q != 16'd0) begin
            dwell_d = dwell_q - 16'd1;
          end else begin
            dwell_d = dwell_cfg_q;
          end
        end
        phase_d = PH_FIRST;
        pair_d  = '0;
      end
      ST_PREP: begin
        rd_en  = 1'b1;
        rd_row = 3'(CHAIN_ROWS - 1);
      end
      ST_EMIT: begin
        // Splice the freshly read row into the byte buffer at its two load points.
        if (phase_q == PH_FIRST) begin
          cur    = {rd_data, 4'b0};
          rd_en  = 1'b1;
          rd_row = 3'(CHAIN_ROWS - 2) - {pair_q, 1'b0};
        end else if (phase_q == PH_SPLIT) begin
          cur    = {buf_q[BUF_BITS-1 -: 4], rd_data};
          rd_en  = (pair_q != PAIR_LAST);
          rd_row = 3'(CHAIN_ROWS - 3) - {pair_q, 1'b0};
        end
        buf_d              = {cur[BUF_BITS-9:0], 8'b0};
        result_valid_d     = 1'b1;
        result_d.column    = 4'(scan_col_q);
        result_d.data_byte = cur[BUF_BITS-1 -: 8];
        result_d.last      = last_byte;
        if (phase_q == PH_LAST) begin
          phase_d = PH_FIRST;
          pair_d  = pair_q + 2'd1;
        end else begin
          phase_d = phase_q + 4'd1;
        end
        if (last_byte) begin
          scan_col_d = (32'(scan_col_q) == NUM_COLUMNS - 1) ? '0 : scan_col_q + CW'(1);
        end
      end
      default: begin
        result_valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      dwell_cfg_q    <= DWELL_RESET;
      dwell_q        <= '0;
      scan_col_q     <= '0;
      phase_q        <= PH_FIRST;
      pair_q         <= '0;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      dwell_q        <= dwell_d;
      scan_col_q     <= scan_col_d;
      phase_q        <= phase_d;
      pair_q         <= pair_d;
      result_valid_q <= result_valid_d;
      if (cfg_we_i) begin
        dwell_cfg_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    buf_q    <= buf_d;
    result_q <= result_d;
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

  // A result only follows a cycle of byte emission.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == ST_EMIT))
    else $error("result strobe without emission");

  // The latch byte closes the frame: no result directly after it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.last) |=> !result_valid_o)
    else $error("result after latch byte");

  // The byte phase never runs past the ninth byte of a row pair.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (phase_q <= PH_LAST))
    else $error("byte phase out of range");

  // A tick on an expired dwell opens a scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_go |=> (state_q == ST_PREP))
    else $error("scan not started");

  // The column advances only at the end of a scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(last_byte) |-> $stable(scan_col_q))
    else $error("scan column moved mid-scan");

endmodule

### tb/led_matrix_column_scan_shifter_tb.sv
// Self-checking testbench for the LED matrix column scan shifter.
`timescale 1ns / 1ps
module led_matrix_column_scan_shifter_tb;
  import lmcs_pkg::*;

  localparam int unsigned COLS       = 16;
  localparam int unsigned ROWS       = 8;
  localparam int unsigned SCAN_BYTES = 36;
  localparam int unsigned QUIET_MAX  = 2000;  // cycles with no transaction before giving up
  localparam int unsigned SETTLE     = 40;    // covers one full scan plus the output register
  localparam logic [1:0]  OP_SPARE   = 2'd3;  // unused code, block must ignore it

  // One row of the directed table: the command, and where the scan it
  // causes is easy to read off, the column and the byte every slot carries.
  typedef struct packed {
    cmd_t       cmd;
    logic       typed;
    logic [3:0] col;
    logic [7:0] fill;
  } dir_row_t;

  localparam int DIR_ROWS = 18;

  logic    clk_i = 1'b0;
  logic    rst_ni;
  logic    start;
  logic    busy;
  cmd_t    cmd_i;
  logic    result_valid_o;
  result_t result_o;
  logic    cfg_we_i;
  logic [15:0] cfg_wdata_i;

  // Framebuffer, scan position and dwell counter as the block should hold them.
  pixel_t      fb_pixels [COLS][ROWS];
  logic [3:0]  scan_col;
  logic [15:0] dwell_left;
  logic [15:0] dwell_reload;

  result_t     scan_bytes_due [$];
  result_t     due_byte;
  int unsigned err_cnt = 0;
  int unsigned quiet_cycles = 0;

  dir_row_t dir_tbl [DIR_ROWS] = '{
    // fill column 0 with full scale on every channel
    {OP_WRITE, 4'd0, 3'd0, 12'hFFF, 12'hFFF, 12'hFFF, 1'b0, 4'd0, 8'h00},
    {OP_WRITE, 4'd0, 3'd1, 12'hFFF, 12'hFFF, 12'hFFF, 1'b0, 4'd0, 8'h00},
    {OP_WRITE, 4'd0, 3'd2, 12'hFFF, 12'hFFF, 12'hFFF, 1'b0, 4'd0, 8'h00},
    {OP_WRITE, 4'd0, 3'd3, 12'hFFF, 12'hFFF, 12'hFFF, 1'b0, 4'd0, 8'h00},
    {OP_WRITE, 4'd0, 3'd4, 12'hFFF, 12'hFFF, 12'hFFF, 1'b0, 4'd0, 8'h00},
    {OP_WRITE, 4'd0, 3'd5, 12'hFFF, 12'hFFF, 12'hFFF, 1'b0, 4'd0, 8'h00},
    {OP_WRITE, 4'd0, 3'd6, 12'hFFF, 12'hFFF, 12'hFFF, 1'b0, 4'd0, 8'h00},
    {OP_WRITE, 4'd0, 3'd7, 12'hFFF, 12'hFFF, 12'hFFF, 1'b0, 4'd0, 8'h00},
    // first tick after reset finds the counter at zero: column 0, all ones
    {OP_TICK,  4'd0, 3'd0, 12'h000, 12'h000, 12'h000, 1'b1, 4'd0, 8'hFF},
    // a pixel that the clear below must wipe out
    {OP_WRITE, 4'd1, 3'd5, 12'hFFF, 12'hFFF, 12'hFFF, 1'b0, 4'd0, 8'h00},
    {OP_CLEAR, 4'd0, 3'd0, 12'h000, 12'h000, 12'h000, 1'b0, 4'd0, 8'h00},
    // unused operation with every field at its top: nothing may change
    {OP_SPARE, 4'hF, 3'h7, 12'hFFF, 12'hFFF, 12'hFFF, 1'b0, 4'd0, 8'h00},
    {OP_WRITE, 4'd15, 3'd7, 12'hFFF, 12'h000, 12'h000, 1'b0, 4'd0, 8'h00},
    // single colours and one mix on column 1 to pin down the channel order
    {OP_WRITE, 4'd1, 3'd0, 12'h000, 12'hFFF, 12'h000, 1'b0, 4'd0, 8'h00},
    {OP_WRITE, 4'd1, 3'd7, 12'h000, 12'h000, 12'hFFF, 1'b0, 4'd0, 8'h00},
    {OP_WRITE, 4'd1, 3'd3, 12'hA5A, 12'h5A5, 12'h0F0, 1'b0, 4'd0, 8'h00},
    {OP_WRITE, 4'd0, 3'd4, 12'h000, 12'h000, 12'h000, 1'b0, 4'd0, 8'h00},
    // counter now non-zero: this tick only counts down
    {OP_TICK,  4'd0, 3'd0, 12'h000, 12'h000, 12'h000, 1'b0, 4'd0, 8'h00}
  };

  led_matrix_column_scan_shifter i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Update the framebuffer copy for one command and queue the bytes of any
  // scan it triggers. Typed rows queue the hand-written bytes instead.
  task automatic apply_command(input cmd_t c, input logic typed, input logic [3:0] col,
                               input logic [7:0] fill);
    logic [8*SCAN_BYTES-1:0] frame;
    result_t                 r;
    case (c.operation)
      OP_WRITE: begin
        fb_pixels[c.x][c.y] = {c.blue, c.red, c.green};
      end
      OP_CLEAR: begin
        for (int i = 0; i < COLS; i++)
          for (int j = 0; j < ROWS; j++)
            fb_pixels[i][j] = '0;
      end
      OP_TICK: begin
        if (dwell_left != 16'd0) begin
          dwell_left = dwell_left - 16'd1;
        end else begin
          // Stack rows 7 down to 0, each blue, red, green, MSB first.
          frame = '0;
          for (int row = ROWS - 1; row >= 0; row--)
            frame = {frame[8*SCAN_BYTES-37:0], fb_pixels[scan_col][row]};
          for (int k = 0; k < SCAN_BYTES; k++) begin
            r.column    = typed ? col : scan_col;
            r.data_byte = typed ? fill : frame[8*SCAN_BYTES-1-8*k -: 8];
            r.last      = (k == SCAN_BYTES - 1);
            scan_bytes_due.push_back(r);
          end
          scan_col   = scan_col + 4'd1;  // wraps at 16 by width
          dwell_left = dwell_reload;
        end
      end
      default: begin
        // unused code: drop silently
      end
    endcase
  endtask

  // Present one command, optionally after a random gap, and hold it until
  // the block takes the transaction. Start stays high on return so that a
  // following command can go out back to back.
  task automatic send_cmd(input cmd_t c, input int unsigned idle_pct, input logic typed,
                          input logic [3:0] col, input logic [7:0] fill);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy);
    apply_command(c, typed, col, fill);
  endtask

  function automatic logic [11:0] pick_level();
    case ($urandom_range(3))
      0:       return 12'h000;
      1:       return 12'hFFF;
      default: return 12'($urandom_range(4095));
    endcase
  endfunction

  // Random fields around a given operation; writes favour the next column to
  // be scanned so that most frames carry content.
  function automatic cmd_t rand_cmd(input logic [1:0] op);
    cmd_t c;
    c.operation = op;
    c.x         = ($urandom_range(1) == 0) ? scan_col : 4'($urandom_range(15));
    c.y         = 3'($urandom_range(7));
    c.red       = pick_level();
    c.green     = pick_level();
    c.blue      = pick_level();
    return c;
  endfunction

  // Let the block drain completely, then write the dwell register.
  task automatic set_dwell(input logic [15:0] value);
    start <= 1'b0;
    do @(posedge clk_i); while (scan_bytes_due.size() != 0 || busy);
    repeat (3) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    dwell_reload = value;
  endtask

  task automatic run_random(input int unsigned n, input int unsigned idle_pct);
    int unsigned pick;
    logic [1:0]  op;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 50)      op = OP_WRITE;
      else if (pick < 86) op = OP_TICK;
      else if (pick < 92) op = OP_CLEAR;
      else                op = OP_SPARE;
      send_cmd(rand_cmd(op), idle_pct, 1'b0, 4'd0, 8'd0);
    end
  endtask

  // Check every result against the oldest byte still due.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (scan_bytes_due.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result, expected none actual %p", $time, result_o);
      end else begin
        due_byte = scan_bytes_due.pop_front();
        if (result_o.column !== due_byte.column) begin
          err_cnt++;
          $display("%0t: column mismatch, expected %0d actual %0d", $time,
                   due_byte.column, result_o.column);
        end
        if (result_o.data_byte !== due_byte.data_byte) begin
          err_cnt++;
          $display("%0t: data_byte mismatch, expected %02h actual %02h", $time,
                   due_byte.data_byte, result_o.data_byte);
        end
        if (result_o.last !== due_byte.last) begin
          err_cnt++;
          $display("%0t: last mismatch, expected %0b actual %0b", $time,
                   due_byte.last, result_o.last);
        end
      end
    end
  end

  // Watchdog: end the run if no transaction moves for too long.
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_MAX) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    cmd_i       <= '0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    for (int i = 0; i < COLS; i++)
      for (int j = 0; j < ROWS; j++)
        fb_pixels[i][j] = '0;
    scan_col     = 4'd0;
    dwell_left   = 16'd0;
    dwell_reload = DWELL_RESET;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset dwell value.
    for (int i = 0; i < DIR_ROWS; i++)
      send_cmd(dir_tbl[i].cmd, 0, dir_tbl[i].typed, dir_tbl[i].col, dir_tbl[i].fill);

    // Tick the counter down from the reset dwell to zero, then drop the
    // reload to zero and tick once more, so that the random part starts
    // with scans on every tick.
    while (dwell_left != 16'd0)
      send_cmd(rand_cmd(OP_TICK), 0, 1'b0, 4'd0, 8'd0);
    set_dwell(16'd0);
    send_cmd(rand_cmd(OP_TICK), 0, 1'b0, 4'd0, 8'd0);

    // Random phases over several dwell settings, extremes included.
    run_random(60, 25);
    set_dwell(16'd3);
    run_random(60, 65);
    set_dwell(16'd1);
    run_random(50, 0);
    set_dwell(16'hFFFF);
    run_random(22, 0);

    // Release start, drain, and give the block time to show anything stray.
    start <= 1'b0;
    while (scan_bytes_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (err_cnt == 0 && scan_bytes_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/lmcs_pkg.sv
rtl/lmcs_pixel_store.sv
rtl/led_matrix_column_scan_shifter.sv
tb/led_matrix_column_scan_shifter_tb.sv
